@@ rtl/segmented_memory_access_unit_defines.svh @@
// Assertion macros for the segmented memory access unit.
`ifndef SEGMENTED_MEMORY_ACCESS_UNIT_DEFINES_SVH
`define SEGMENTED_MEMORY_ACCESS_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Check cons in the same cycle as ante.
`define SMAU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segmented memory access unit: assertion failed");
// Check cons in the cycle after ante.
`define SMAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segmented memory access unit: assertion failed");
`else
`define SMAU_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SMAU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/smau_pkg.sv @@
// Shared types and constants of the segmented memory access unit.
package smau_pkg;

    localparam int NUM_SEGMENTS = 4;
    localparam int SEG_SLOTS    = 4;
    localparam int SEG_IW       = $clog2(SEG_SLOTS);
    localparam int MEM_BYTES    = 16384;
    localparam int MEM_AW       = $clog2(MEM_BYTES);

    localparam int ADDR_W       = 32;
    localparam int DATA_W       = 32;
    localparam int SEG_NUM_W    = 16;
    localparam int OFFSET_W     = 16;
    localparam int PHYS_W       = 17;
    localparam int NBYTES_W     = 3;
    localparam int MAX_BYTES    = 4;
    localparam int BASE_W       = 15;
    localparam int SIZE_W       = 16;
    localparam int LIMIT_W      = 16;

    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_NUM_REGS = 2 * SEG_SLOTS;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_SEG = 2'd1,
        ST_BOUNDS  = 2'd2
    } status_t;

    // Low bit of a register index picks base or size of a segment
    typedef enum logic {
        CFG_BASE = 1'b0,
        CFG_SIZE = 1'b1
    } cfg_kind_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CALC,
        S_CHECK,
        S_ACCESS,
        S_DRAIN,
        S_RESP
    } state_t;

    // Segment lookup result; base and size are non-negative when ok is set
    typedef struct packed {
        logic                ok;
        logic [BASE_W-2:0]   base;
        logic [SIZE_W-2:0]   size;
    } seg_info_t;

    // One byte-wide memory access
    typedef struct packed {
        logic              we;
        logic              re;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;

endpackage

@@ rtl/smau_if.sv @@
// Request, response and configuration channel interfaces.
interface smau_in_if;
    import smau_pkg::*;
    logic                valid;
    logic                ready;
    logic                op;
    logic [ADDR_W-1:0]   logical_address;
    logic [NBYTES_W-1:0] access_bytes;
    logic [DATA_W-1:0]   write_data;
    modport source (output valid, op, logical_address, access_bytes, write_data,
                    input ready);
    modport sink (input valid, op, logical_address, access_bytes, write_data,
                  output ready);
endinterface

interface smau_out_if;
    import smau_pkg::*;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic [PHYS_W-1:0] physical_address;
    logic [1:0]        status;
    modport source (output valid, read_data, physical_address, status, input ready);
    modport sink (input valid, read_data, physical_address, status, output ready);
endinterface

interface smau_cfg_if;
    import smau_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/smau_seg_table.sv @@
// Segment base and size registers with the segment lookup.
module smau_seg_table (
    input  logic                             clk,
    input  logic                             rst_n,
    smau_cfg_if.sink                         cfg,
    input  logic [smau_pkg::SEG_NUM_W-1:0]   seg_num,
    output smau_pkg::seg_info_t              seg_info
);
    import smau_pkg::*;

    logic [BASE_W-1:0] base_reg [SEG_SLOTS];
    logic [SIZE_W-1:0] size_reg [SEG_SLOTS];
    logic [SEG_IW-1:0] wr_seg;
    cfg_kind_t         wr_kind;
    logic [SEG_IW-1:0] sel;
    logic              in_range;

    assign cfg.ready = 1'b1;
    assign wr_seg    = cfg.index[SEG_IW:1];
    assign wr_kind   = cfg_kind_t'(cfg.index[0]);

    // Write a base or size register; drop indexes past the table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SEG_SLOTS; i++)
            begin
                base_reg[i] <= '1;
                size_reg[i] <= '1;
            end
        end
        else if (cfg.valid && cfg.ready && (cfg.index < CFG_IDX_W'(CFG_NUM_REGS)))
        begin
            unique case (wr_kind)
                CFG_BASE: base_reg[wr_seg] <= cfg.data[BASE_W-1:0];
                CFG_SIZE: size_reg[wr_seg] <= cfg.data[SIZE_W-1:0];
            endcase
        end
    end

    // Look up the segment; a negative base or size marks it unused
    assign sel      = seg_num[SEG_IW-1:0];
    assign in_range = (seg_num < SEG_NUM_W'(NUM_SEGMENTS));

    always_comb
    begin
        seg_info.ok   = in_range && !base_reg[sel][BASE_W-1] && !size_reg[sel][SIZE_W-1];
        seg_info.base = base_reg[sel][BASE_W-2:0];
        seg_info.size = size_reg[sel][SIZE_W-2:0];
    end

endmodule

@@ rtl/smau_byte_ram.sv @@
// Byte-wide data memory with one access port and registered read data.
module smau_byte_ram (
    input  logic               clk,
    input  smau_pkg::mem_req_t mem_req,
    output logic [7:0]         rdata
);
    import smau_pkg::*;

    logic [7:0] mem [MEM_BYTES];
    logic [7:0] rdata_reg;

    // Write or read one byte
    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.addr] <= mem_req.wdata;
        end
        if (mem_req.re)
        begin
            rdata_reg <= mem[mem_req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/smau_ctrl.sv @@
// Sequencer: translation, bounds check and byte-serial memory transfer.
module smau_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    smau_in_if.sink                          req,
    smau_out_if.source                       rsp,
    output logic [smau_pkg::SEG_NUM_W-1:0]   seg_num,
    input  smau_pkg::seg_info_t              seg_info,
    output smau_pkg::mem_req_t               mem_req,
    input  logic [7:0]                       mem_rdata
);
    import smau_pkg::*;

    localparam logic [MEM_AW-1:0] LAST_ADDR = MEM_AW'(MEM_BYTES - 1);

    state_t              state_reg, state_next;
    logic [MEM_AW-1:0]   addr_reg, addr_next;
    logic [NBYTES_W-1:0] cnt_reg, cnt_next;
    logic                rd_pend_reg, rd_pend_next;
    logic                out_valid_reg, out_valid_next;

    op_t                 op_reg, op_next;
    logic [SEG_NUM_W-1:0] seg_num_reg, seg_num_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [NBYTES_W-1:0] nbytes_reg, nbytes_next;
    logic [DATA_W-1:0]   wdata_reg, wdata_next;
    logic [PHYS_W-1:0]   phys_reg, phys_next;
    logic [LIMIT_W-1:0]  limit_reg, limit_next;
    status_t             status_reg, status_next;
    logic [DATA_W-1:0]   shift_reg, shift_next;
    logic [DATA_W-1:0]   out_rdata_reg, out_rdata_next;
    logic [PHYS_W-1:0]   out_phys_reg, out_phys_next;
    status_t             out_status_reg, out_status_next;

    logic                accept;
    logic                out_room;
    logic [PHYS_W-1:0]   end_addr;
    logic                bounds_fail;
    logic [DATA_W-1:0]   wdata_aligned;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_room  = !out_valid_reg || rsp.ready;
    assign seg_num   = seg_num_reg;

    assign end_addr    = phys_reg + PHYS_W'(nbytes_reg);
    assign bounds_fail = (end_addr > {1'b0, limit_reg}) || (end_addr > PHYS_W'(MEM_BYTES));

    // Move the first byte to send into the top of the word
    always_comb
    begin
        case (nbytes_reg)
            3'd1:    wdata_aligned = {wdata_reg[7:0], 24'h000000};
            3'd2:    wdata_aligned = {wdata_reg[15:0], 16'h0000};
            3'd3:    wdata_aligned = {wdata_reg[23:0], 8'h00};
            default: wdata_aligned = wdata_reg;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                state_next = seg_info.ok ? S_CHECK : S_RESP;
            end
            S_CHECK:
            begin
                if (bounds_fail || (nbytes_reg == '0))
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_ACCESS;
                end
            end
            S_ACCESS:
            begin
                if (cnt_reg == NBYTES_W'(1))
                begin
                    state_next = (op_reg == OP_READ) ? S_DRAIN : S_RESP;
                end
            end
            S_DRAIN:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_room)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory port: zero sweep after reset, then one byte per cycle
    always_comb
    begin
        mem_req.we    = (state_reg == S_CLEAR) ||
                        ((state_reg == S_ACCESS) && (op_reg == OP_WRITE));
        mem_req.re    = (state_reg == S_ACCESS) && (op_reg == OP_READ);
        mem_req.addr  = addr_reg;
        mem_req.wdata = (state_reg == S_CLEAR) ? 8'h00 : shift_reg[DATA_W-1:DATA_W-8];
    end

    // Datapath updates
    always_comb
    begin
        addr_next       = addr_reg;
        cnt_next        = cnt_reg;
        rd_pend_next    = mem_req.re;
        out_valid_next  = out_valid_reg;
        op_next         = op_reg;
        seg_num_next    = seg_num_reg;
        offset_next     = offset_reg;
        nbytes_next     = nbytes_reg;
        wdata_next      = wdata_reg;
        phys_next       = phys_reg;
        limit_next      = limit_reg;
        status_next     = status_reg;
        shift_next      = shift_reg;
        out_rdata_next  = out_rdata_reg;
        out_phys_next   = out_phys_reg;
        out_status_next = out_status_reg;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                addr_next = addr_reg + MEM_AW'(1);
            end
            S_IDLE:
            begin
                // Capture the request, counts above four become four
                if (accept)
                begin
                    op_next      = op_t'(req.op);
                    seg_num_next = req.logical_address[ADDR_W-1:OFFSET_W];
                    offset_next  = req.logical_address[OFFSET_W-1:0];
                    nbytes_next  = (req.access_bytes > NBYTES_W'(MAX_BYTES)) ?
                                   NBYTES_W'(MAX_BYTES) : req.access_bytes;
                    wdata_next   = req.write_data;
                end
            end
            S_CALC:
            begin
                if (!seg_info.ok)
                begin
                    status_next = ST_BAD_SEG;
                    phys_next   = '0;
                end
                else
                begin
                    phys_next  = PHYS_W'(seg_info.base) + PHYS_W'(offset_reg);
                    limit_next = LIMIT_W'(seg_info.base) + LIMIT_W'(seg_info.size);
                end
            end
            S_CHECK:
            begin
                status_next = bounds_fail ? ST_BOUNDS : ST_OK;
                addr_next   = phys_reg[MEM_AW-1:0];
                cnt_next    = nbytes_reg;
                shift_next  = (op_reg == OP_READ) ? '0 : wdata_aligned;
            end
            S_ACCESS:
            begin
                addr_next = addr_reg + MEM_AW'(1);
                cnt_next  = cnt_reg - NBYTES_W'(1);
                if (op_reg == OP_WRITE)
                begin
                    shift_next = {shift_reg[DATA_W-9:0], 8'h00};
                end
            end
            S_RESP:
            begin
                if (out_room)
                begin
                    out_valid_next  = 1'b1;
                    out_rdata_next  = ((status_reg == ST_OK) && (op_reg == OP_READ)) ?
                                      shift_reg : '0;
                    out_phys_next   = phys_reg;
                    out_status_next = status_reg;
                end
            end
            default:
            begin
            end
        endcase

        // Shift in a returned read byte
        if (rd_pend_reg)
        begin
            shift_next = {shift_reg[DATA_W-9:0], mem_rdata};
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            cnt_reg       <= cnt_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        seg_num_reg    <= seg_num_next;
        offset_reg     <= offset_next;
        nbytes_reg     <= nbytes_next;
        wdata_reg      <= wdata_next;
        phys_reg       <= phys_next;
        limit_reg      <= limit_next;
        status_reg     <= status_next;
        shift_reg      <= shift_next;
        out_rdata_reg  <= out_rdata_next;
        out_phys_reg   <= out_phys_next;
        out_status_reg <= out_status_next;
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.read_data        = out_rdata_reg;
    assign rsp.physical_address = out_phys_reg;
    assign rsp.status           = out_status_reg;

endmodule

@@ rtl/segmented_memory_access_unit.sv @@
// Top level of the segmented memory access unit.
`include "segmented_memory_access_unit_defines.svh"

// Translates a logical address (segment number in bits 31:16, offset in 15:0)
// through four base/size segment registers and reads or writes up to four
// bytes big-endian in a 16384-byte memory, returning one response per request.
// After reset the memory is swept to zero, one byte a cycle;
// requests are held off meanwhile, configuration writes are taken at any time.
// A request then passes through the states calc, check, access and, for a
// read, drain before the response state; an invalid segment goes from calc
// straight to the response, an out-of-bounds or zero-byte access from check.
// The byte-wide memory port moves one byte a cycle during access.
// A finished response sits in an output register, so the next request can be
// taken while it waits.
module segmented_memory_access_unit (
    input logic         clk,
    input logic         rst_n,
    smau_in_if.sink     req,
    smau_out_if.source  rsp,
    smau_cfg_if.sink    cfg
);
    import smau_pkg::*;

    logic [SEG_NUM_W-1:0] seg_num;
    seg_info_t            seg_info;
    mem_req_t             mem_req;
    logic [7:0]           mem_rdata;

    smau_seg_table u_seg_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .seg_num  (seg_num),
        .seg_info (seg_info)
    );

    smau_byte_ram u_byte_ram (
        .clk     (clk),
        .mem_req (mem_req),
        .rdata   (mem_rdata)
    );

    smau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .seg_num   (seg_num),
        .seg_info  (seg_info),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    // A taken request keeps the unit busy for the following cycle
    `SMAU_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req.valid && req.ready, !req.ready)
    // Memory is only written while no request is being taken
    `SMAU_ASSERT_NOW(a_no_write_when_idle, clk, rst_n, mem_req.we, !req.ready)
    // A failed access returns no data
    `SMAU_ASSERT_NOW(a_err_no_data, clk, rst_n, rsp.valid && (rsp.status != ST_OK), rsp.read_data == '0)
    // An invalid segment reports physical address zero
    `SMAU_ASSERT_NOW(a_bad_seg_addr, clk, rst_n, rsp.valid && (rsp.status == ST_BAD_SEG), rsp.physical_address == '0)

endmodule

@@ tb/sv/segmented_memory_access_unit_tb.sv @@
// Self-checking testbench for the segmented memory access unit, with a shadow memory model.
module segmented_memory_access_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import smau_pkg::*;

    localparam int CLK_HALF_NS  = 5;
    localparam int RUN_LIMIT_NS = 5_000_000;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [PHYS_W-1:0] physical_address;
        status_t           status;
    } access_result_t;

    typedef enum int {
        MAP_DENSE,
        MAP_EXTREME,
        MAP_RAW
    } map_style_t;

    logic clk;
    logic rst_n;

    smau_in_if  req_if ();
    smau_out_if rsp_if ();
    smau_cfg_if cfg_if ();

    segmented_memory_access_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    // Shadow copy of the memory and the segment table
    logic [7:0]     mem_shadow [MEM_BYTES];
    int             segment_base [SEG_SLOTS];
    int             segment_len [SEG_SLOTS];
    logic [15:0]    map_base [SEG_SLOTS];
    logic [15:0]    map_len [SEG_SLOTS];
    access_result_t pending_results [$];

    int error_count       = 0;
    int responses_checked = 0;
    int reads_ok          = 0;
    int writes_ok         = 0;
    int bad_segment_count = 0;
    int out_of_bounds     = 0;
    int register_writes   = 0;
    int maps_applied      = 0;

    // Idling controls shared by the sender and the response sink
    int stall_pct    = 0;
    int gap_max      = 0;
    int burst_left   = 0;
    bit hold_request = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF_NS clk = ~clk;
    end

    // Drop ready on a random pattern, or for a long stretch when asked
    initial
    begin : response_sink
        int   stall_left;
        int   hold_left;
        logic rdy_next;
        stall_left = 0;
        hold_left  = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy_next = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rdy_next = 1'b0;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(0, 5);
                rdy_next   = 1'b0;
            end
            else
            begin
                rdy_next = 1'b1;
            end
            rsp_if.ready <= rdy_next;
        end
    end

    // Compare each accepted response with the oldest expected one
    always @(posedge clk)
    begin : response_check
        access_result_t want;
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected response: read_data %h physical_address %h status %0d",
                       rsp_if.read_data, rsp_if.physical_address, rsp_if.status);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                responses_checked++;
                if (rsp_if.read_data !== want.read_data)
                begin
                    $error("read_data: expected %h, got %h", want.read_data, rsp_if.read_data);
                    error_count++;
                end
                if (rsp_if.physical_address !== want.physical_address)
                begin
                    $error("physical_address: expected %h, got %h",
                           want.physical_address, rsp_if.physical_address);
                    error_count++;
                end
                if (rsp_if.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                    error_count++;
                end
            end
        end
    end

    // Translate one request and apply it to the shadow memory
    task automatic translate_and_access(input op_t op, input logic [ADDR_W-1:0] laddr,
                                        input logic [NBYTES_W-1:0] nbytes,
                                        input logic [DATA_W-1:0] wdata,
                                        output access_result_t res);
        int unsigned seg;
        int unsigned offset;
        int unsigned count;
        int unsigned base;
        int unsigned limit;
        int unsigned phys;
        int unsigned stop;
        res.read_data        = '0;
        res.physical_address = '0;
        res.status           = ST_OK;
        seg    = laddr[ADDR_W-1:OFFSET_W];
        offset = laddr[OFFSET_W-1:0];
        count  = (nbytes > MAX_BYTES) ? MAX_BYTES : nbytes;
        if (seg >= NUM_SEGMENTS)
        begin
            res.status = ST_BAD_SEG;
        end
        else if (segment_base[seg] < 0 || segment_len[seg] < 0)
        begin
            res.status = ST_BAD_SEG;
        end
        else
        begin
            base  = segment_base[seg];
            limit = base + segment_len[seg];
            phys  = base + offset;
            stop  = phys + count;
            res.physical_address = phys[PHYS_W-1:0];
            if (stop > limit || stop > MEM_BYTES)
                res.status = ST_BOUNDS;
            else if (op == OP_READ)
                for (int i = 0; i < count; i++)
                    res.read_data = {res.read_data[DATA_W-9:0], mem_shadow[phys + i]};
            else
                for (int i = 0; i < count; i++)
                    mem_shadow[phys + i] = wdata[8 * (count - 1 - i) +: 8];
        end
        case (res.status)
            ST_OK:      if (op == OP_READ) reads_ok++; else writes_ok++;
            ST_BAD_SEG: bad_segment_count++;
            default:    out_of_bounds++;
        endcase
    endtask

    // Present one request and hold it until taken; valid stays high afterwards
    task automatic send_access(input op_t op, input logic [ADDR_W-1:0] laddr,
                               input logic [NBYTES_W-1:0] nbytes,
                               input logic [DATA_W-1:0] wdata);
        access_result_t want;
        req_if.valid           <= 1'b1;
        req_if.op              <= op;
        req_if.logical_address <= laddr;
        req_if.access_bytes    <= nbytes;
        req_if.write_data      <= wdata;
        do @(posedge clk); while (req_if.ready !== 1'b1);
        translate_and_access(op, laddr, nbytes, wdata, want);
        pending_results.push_back(want);
    endtask

    // Send in bursts with random gaps between them
    task automatic offer_access(input op_t op, input logic [ADDR_W-1:0] laddr,
                                input logic [NBYTES_W-1:0] nbytes,
                                input logic [DATA_W-1:0] wdata);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        send_access(op, laddr, nbytes, wdata);
    endtask

    // Stop offering requests and wait for every response
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Write one register; valid stays high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        int unsigned seg;
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge clk); while (cfg_if.ready !== 1'b1);
        register_writes++;
        seg = idx >> 1;
        if (idx < CFG_NUM_REGS)
        begin
            if (cfg_kind_t'(idx[0]) == CFG_BASE)
                segment_base[seg] = $signed(val[BASE_W-1:0]);
            else
                segment_len[seg] = $signed(val[SIZE_W-1:0]);
        end
    endtask

    // Program the whole table, plus one write to an unused index
    task automatic apply_map();
        for (int s = 0; s < SEG_SLOTS; s++)
        begin
            write_reg({3'(s), CFG_BASE}, map_base[s]);
            write_reg({3'(s), CFG_SIZE}, map_len[s]);
        end
        write_reg(CFG_IDX_W'($urandom_range(CFG_NUM_REGS, 2 ** CFG_IDX_W - 1)),
                  CFG_DATA_W'($urandom()));
        cfg_if.valid <= 1'b0;
        maps_applied++;
    endtask

    task automatic choose_map(input map_style_t style);
        for (int s = 0; s < SEG_SLOTS; s++)
        begin
            case (style)
                MAP_DENSE:
                begin
                    // Overlapping windows so reads see earlier writes
                    map_base[s] = 16'($urandom_range(0, 600));
                    map_len[s]  = 16'($urandom_range(8, 256));
                    if ($urandom_range(0, 7) == 0)
                        map_base[s] = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'hFFFF;
                end
                MAP_EXTREME:
                begin
                    case ($urandom_range(0, 3))
                        0:       map_base[s] = 16'd0;
                        1:       map_base[s] = 16'(MEM_BYTES - 1);
                        2:       map_base[s] = 16'(MEM_BYTES - 1 - $urandom_range(0, 8));
                        default: map_base[s] = 16'($urandom_range(0, MEM_BYTES - 1));
                    endcase
                    case ($urandom_range(0, 3))
                        0:       map_len[s] = 16'd0;
                        1:       map_len[s] = 16'(MEM_BYTES);
                        2:       map_len[s] = 16'hFFFF;
                        default: map_len[s] = 16'($urandom_range(1, 64));
                    endcase
                end
                default:
                begin
                    map_base[s] = 16'($urandom());
                    map_len[s]  = 16'($urandom());
                end
            endcase
        end
        apply_map();
    endtask

    // Mostly well-formed accesses into configured segments, some noise
    task automatic random_access();
        logic [ADDR_W-1:0]   laddr;
        logic [NBYTES_W-1:0] nbytes;
        int unsigned         seg;
        int unsigned         span;
        int                  len;
        op_t                 op;
        op = op_t'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 80)
        begin
            seg  = $urandom_range(0, NUM_SEGMENTS - 1);
            len  = segment_len[seg];
            span = (len >= 0) ? len + 2 : 300;
            laddr = {16'(seg), 16'($urandom_range(0, span))};
            // Aim at the segment end now and then
            if (len >= 4 && $urandom_range(0, 3) == 0)
                laddr[OFFSET_W-1:0] = 16'(len - $urandom_range(0, 4));
            if ($urandom_range(0, 9) == 0)
                nbytes = 3'($urandom_range(MAX_BYTES + 1, 7));
            else
                nbytes = 3'($urandom_range(0, MAX_BYTES));
        end
        else
        begin
            laddr  = $urandom();
            nbytes = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 1) != 0)
                laddr[ADDR_W-1:OFFSET_W] = 16'($urandom_range(0, SEG_SLOTS + 1));
        end
        offer_access(op, laddr, nbytes, $urandom());
    endtask

    // Every segment is unused straight after reset
    task automatic test_reset_state();
        gap_max   = 0;
        stall_pct = 0;
        send_access(OP_READ, 32'h0000_0000, 3'd4, 32'h0);
    endtask

    task automatic test_translation_directed();
        wait_drained();
        map_base = '{16'd0, 16'(MEM_BYTES - 1), 16'd100, 16'h7FFF};
        map_len  = '{16'd64, 16'd1, 16'(MEM_BYTES), 16'd10};
        apply_map();
        send_access(OP_WRITE, {16'd0, 16'd0}, 3'd4, 32'hDEAD_BEEF);
        send_access(OP_READ,  {16'd0, 16'd0}, 3'd4, 32'h0);
        send_access(OP_READ,  {16'd0, 16'd1}, 3'd2, 32'h0);
        // Byte counts above four clamp to four
        send_access(OP_READ,  {16'd0, 16'd0}, 3'd7, 32'h0);
        send_access(OP_WRITE, {16'd0, 16'd2}, 3'd1, 32'hFFFF_FF5A);
        send_access(OP_READ,  {16'd0, 16'd0}, 3'd4, 32'h0);
        // Zero-length access exactly at the segment end
        send_access(OP_WRITE, {16'd0, 16'd64}, 3'd0, 32'hFFFF_FFFF);
        send_access(OP_READ,  {16'd0, 16'd61}, 3'd4, 32'h0);
        send_access(OP_READ,  {16'd0, 16'd60}, 3'd4, 32'h0);
        // Last byte of memory
        send_access(OP_WRITE, {16'd1, 16'd0}, 3'd1, 32'h0000_00A5);
        send_access(OP_READ,  {16'd1, 16'd0}, 3'd1, 32'h0);
        send_access(OP_WRITE, {16'd1, 16'd0}, 3'd2, 32'h0000_1234);
        // Segment larger than what is left of the memory
        send_access(OP_WRITE, {16'd2, 16'd16280}, 3'd4, 32'hFFFF_FFFF);
        send_access(OP_READ,  {16'd2, 16'd16280}, 3'd4, 32'h0);
        send_access(OP_READ,  {16'd2, 16'd16281}, 3'd4, 32'h0);
        send_access(OP_READ,  {16'd3, 16'd0}, 3'd1, 32'h0);
        send_access(OP_READ,  {16'd4, 16'd0}, 3'd1, 32'h0);
        send_access(OP_WRITE, 32'hFFFF_FFFF, 3'd4, 32'hFFFF_FFFF);
        send_access(OP_READ,  {16'd0, 16'hFFFF}, 3'd1, 32'h0);
    endtask

    // Negative values other than all ones, and an empty segment
    task automatic test_invalid_encodings();
        wait_drained();
        map_base = '{16'h4000, 16'd0, 16'd50, 16'hFFFF};
        map_len  = '{16'd64, 16'h8000, 16'd0, 16'hFFFF};
        apply_map();
        send_access(OP_READ,  {16'd0, 16'd0}, 3'd1, 32'h0);
        send_access(OP_WRITE, {16'd1, 16'd0}, 3'd1, 32'h55);
        send_access(OP_READ,  {16'd2, 16'd0}, 3'd0, 32'h0);
        send_access(OP_WRITE, {16'd2, 16'd0}, 3'd1, 32'h77);
        send_access(OP_READ,  {16'd3, 16'd0}, 3'd2, 32'h0);
    endtask

    task automatic test_random_mix(input map_style_t style, input int count,
                                   input int gap, input int stall);
        wait_drained();
        gap_max   = gap;
        stall_pct = stall;
        choose_map(style);
        repeat (count) random_access();
    endtask

    // Hold the response side off while requests keep coming
    task automatic test_backpressure();
        wait_drained();
        gap_max   = 0;
        stall_pct = 0;
        choose_map(MAP_DENSE);
        hold_request = 1'b1;
        repeat (40) random_access();
    endtask

    initial
    begin
        mem_shadow   = '{default: '0};
        segment_base = '{default: -1};
        segment_len  = '{default: -1};
        rst_n = 1'b0;
        req_if.valid           <= 1'b0;
        req_if.op              <= OP_READ;
        req_if.logical_address <= '0;
        req_if.access_bytes    <= '0;
        req_if.write_data      <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= '0;
        cfg_if.data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_translation_directed();
        test_invalid_encodings();
        test_random_mix(MAP_DENSE, 180, 6, 30);
        test_random_mix(MAP_EXTREME, 120, 3, 50);
        test_random_mix(MAP_RAW, 100, 10, 20);
        test_backpressure();
        test_random_mix(MAP_DENSE, 160, 0, 0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered: %0d reads and %0d writes in bounds, %0d bad segment, %0d out of bounds",
                 reads_ok, writes_ok, bad_segment_count, out_of_bounds);
        $display("covered: %0d responses compared, %0d register writes over %0d segment maps",
                 responses_checked, register_writes, maps_applied);
        if (error_count == 0)
            $display("segmented_memory_access_unit_tb: done, clean");
        else
            $display("segmented_memory_access_unit_tb: done, errors");
        $finish;
    end

    // End a hung run
    initial
    begin
        #RUN_LIMIT_NS;
        $display("timeout with %0d responses outstanding", pending_results.size());
        $display("segmented_memory_access_unit_tb: done, errors");
        $finish;
    end

endmodule
